### rtl/dds_pkg.sv
package dds_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_REMIND_INTERVAL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_REMINDERS   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TAKE_WAIT       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OPEN_DELAY      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DISPENSE_DELAY  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_DELAY     = 3'd5;

	localparam logic [31:0] RST_REMIND_INTERVAL = 32'd300000;
	localparam logic [7:0]  RST_MAX_REMINDERS   = 8'd3;
	localparam logic [31:0] RST_TAKE_WAIT       = 32'd30000;
	localparam logic [15:0] RST_OPEN_DELAY      = 16'd1000;
	localparam logic [15:0] RST_DISPENSE_DELAY  = 16'd1500;
	localparam logic [15:0] RST_CLOSE_DELAY     = 16'd1000;

	localparam logic OP_POLL    = 1'b0;
	localparam logic OP_TRIGGER = 1'b1;

	localparam logic [1:0] ACT_NONE     = 2'd0;
	localparam logic [1:0] ACT_OPEN     = 2'd1;
	localparam logic [1:0] ACT_DISPENSE = 2'd2;
	localparam logic [1:0] ACT_CLOSE    = 2'd3;

	localparam logic [1:0] NOTIFY_NONE   = 2'd0;
	localparam logic [1:0] NOTIFY_REMIND = 2'd1;
	localparam logic [1:0] NOTIFY_MISSED = 2'd2;

	localparam logic [1:0] LOG_NONE      = 2'd0;
	localparam logic [1:0] LOG_DISPENSED = 2'd1;
	localparam logic [1:0] LOG_MISSED    = 2'd2;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_REMIND = 3'd1,
		PH_WAIT   = 3'd2,
		PH_OPEN   = 3'd3,
		PH_DISP   = 3'd4,
		PH_TAKE   = 3'd5,
		PH_CLOSE  = 3'd6,
		PH_DONE   = 3'd7
	} phase_t;

	typedef struct packed {
		logic        operation;
		logic [31:0] now_ms;
		logic        schedule_pending;
		logic        user_present;
		logic [7:0]  module_number;
	} poll_item_t;

	typedef struct packed {
		logic [2:0] current_phase;
		logic       trigger_accepted;
		logic [1:0] dispenser_command;
		logic [7:0] command_module;
		logic       buzz_start;
		logic [1:0] notify_kind;
		logic [1:0] log_outcome;
		logic       dose_handled;
		logic [7:0] reminder_number;
	} result_item_t;

	typedef struct packed {
		logic [31:0] remind_period_ms;
		logic [7:0]  max_reminders;
		logic [31:0] take_wait_ms;
		logic [15:0] open_delay_ms;
		logic [15:0] dispense_delay_ms;
		logic [15:0] close_delay_ms;
	} cfg_t;

	typedef struct packed {
		phase_t      phase;
		logic [31:0] phase_start;
		logic [31:0] last_remind;
		logic [7:0]  reminders_given;
		logic [7:0]  active_module;
		logic        cmd_issued;
	} seq_state_t;

endpackage

### rtl/dds_if.sv
interface dds_in_if;
	import dds_pkg::*;

	logic       valid;
	logic       ready;
	poll_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface dds_out_if;
	import dds_pkg::*;

	logic         valid;
	logic         ready;
	result_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
	modport mon (input valid, input item, input ready);
endinterface

### rtl/dds_step.sv
module dds_step (
	input  dds_pkg::seq_state_t   st,
	input  dds_pkg::cfg_t         cfg,
	input  dds_pkg::poll_item_t   item,
	output dds_pkg::seq_state_t   nxt,
	output dds_pkg::result_item_t res
);
	import dds_pkg::*;

	logic [31:0] elapsed;
	logic [31:0] since_remind;
	logic [8:0]  remind_cnt;

	assign elapsed      = item.now_ms - st.phase_start;
	assign since_remind = item.now_ms - st.last_remind;
	assign remind_cnt   = {1'b0, st.reminders_given} + 9'd1;

	always_comb begin
		nxt = st;
		res = '0;
		if (item.operation == OP_TRIGGER) begin
			if (st.phase == PH_IDLE) begin
				nxt.active_module    = item.module_number;
				nxt.phase            = PH_REMIND;
				nxt.phase_start      = item.now_ms;
				nxt.cmd_issued       = 1'b0;
				res.trigger_accepted = 1'b1;
			end
		end else begin
			unique case (st.phase)
				PH_IDLE: begin
					if (item.schedule_pending) begin
						nxt.active_module = item.module_number;
						nxt.phase         = PH_REMIND;
						nxt.phase_start   = item.now_ms;
						nxt.cmd_issued    = 1'b0;
					end
				end
				PH_REMIND: begin
					res.buzz_start      = 1'b1;
					res.notify_kind     = NOTIFY_REMIND;
					nxt.reminders_given = 8'd1;
					nxt.last_remind     = item.now_ms;
					nxt.phase           = PH_WAIT;
					nxt.phase_start     = item.now_ms;
					nxt.cmd_issued      = 1'b0;
				end
				PH_WAIT: begin
					if (item.user_present) begin
						nxt.phase       = PH_OPEN;
						nxt.phase_start = item.now_ms;
						nxt.cmd_issued  = 1'b0;
					end else if (since_remind >= cfg.remind_period_ms) begin
						nxt.reminders_given = remind_cnt[8] ? 8'hff : remind_cnt[7:0];
						if (remind_cnt > {1'b0, cfg.max_reminders}) begin
							res.log_outcome  = LOG_MISSED;
							res.notify_kind  = NOTIFY_MISSED;
							res.dose_handled = 1'b1;
							nxt.phase        = PH_IDLE;
							nxt.phase_start  = item.now_ms;
							nxt.cmd_issued   = 1'b0;
						end else begin
							res.buzz_start  = 1'b1;
							nxt.last_remind = item.now_ms;
						end
					end
				end
				PH_OPEN: begin
					if (!st.cmd_issued) begin
						res.dispenser_command = ACT_OPEN;
						nxt.cmd_issued        = 1'b1;
					end
					if (elapsed >= {16'd0, cfg.open_delay_ms}) begin
						nxt.phase       = PH_DISP;
						nxt.phase_start = item.now_ms;
						nxt.cmd_issued  = 1'b0;
					end
				end
				PH_DISP: begin
					if (!st.cmd_issued) begin
						res.dispenser_command = ACT_DISPENSE;
						nxt.cmd_issued        = 1'b1;
					end
					if (elapsed >= {16'd0, cfg.dispense_delay_ms}) begin
						nxt.phase       = PH_TAKE;
						nxt.phase_start = item.now_ms;
						nxt.cmd_issued  = 1'b0;
					end
				end
				PH_TAKE: begin
					if (elapsed >= cfg.take_wait_ms) begin
						nxt.phase       = PH_CLOSE;
						nxt.phase_start = item.now_ms;
						nxt.cmd_issued  = 1'b0;
					end
				end
				PH_CLOSE: begin
					if (!st.cmd_issued) begin
						res.dispenser_command = ACT_CLOSE;
						nxt.cmd_issued        = 1'b1;
					end
					if (elapsed >= {16'd0, cfg.close_delay_ms}) begin
						nxt.phase       = PH_DONE;
						nxt.phase_start = item.now_ms;
						nxt.cmd_issued  = 1'b0;
					end
				end
				PH_DONE: begin
					res.log_outcome  = LOG_DISPENSED;
					res.dose_handled = 1'b1;
					nxt.phase        = PH_IDLE;
					nxt.phase_start  = item.now_ms;
					nxt.cmd_issued   = 1'b0;
				end
			endcase
		end
		res.current_phase   = nxt.phase;
		res.command_module  = nxt.active_module;
		res.reminder_number = nxt.reminders_given;
	end

endmodule

### rtl/dose_dispense_sequencer.sv
// Dose dispense sequencer: steps a dose through reminder, waiting, hatch
// opening, dispensing, taking, hatch closing and completion.
// Channels: poll (sink) takes one item per poll or forced trigger; result
// (source) gives exactly one result item for every accepted poll item.
// Both are valid/ready; an item moves at a clock edge with both high.
// Configuration: cfg_we writes cfg_data into register cfg_index (0..5) at
// a rising edge; other indexes are ignored. Write only while idle.
// Path: an accepted item is held in an input register, then evaluated
// combinationally against the sequencer state and written into the result
// register when that register is empty or its item is being taken.
// Throughput: one item per cycle while result ready is high; the state update
// is a wrapping 32-bit subtract-and-compare plus next-phase selection.
// Stall: while result is held, the input register keeps its item and poll
// ready drops only when both registers are full; nothing is lost.
// Reset (arst_n low): phase idle, times, counts and module cleared, the
// configuration back to its defaults, both registers empty.
module dose_dispense_sequencer (
	input  logic                              clk,
	input  logic                              arst_n,
	dds_in_if.sink                            poll,
	dds_out_if.source                         result,
	input  logic                              cfg_we,
	input  logic [dds_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dds_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import dds_pkg::*;

	cfg_t         cfg_q;
	seq_state_t   state_q;
	seq_state_t   state_nxt;
	poll_item_t   poll_s1;
	logic         vld_s1;
	result_item_t res_s2;
	result_item_t res_nxt;
	logic         vld_s2;
	logic         advance;

	assign advance    = vld_s1 && (!vld_s2 || result.ready);
	assign poll.ready = !vld_s1 || advance;

	assign result.valid = vld_s2;
	assign result.item  = res_s2;

	dds_step u_step (
		.st   (state_q),
		.cfg  (cfg_q),
		.item (poll_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.remind_period_ms  <= RST_REMIND_INTERVAL;
			cfg_q.max_reminders     <= RST_MAX_REMINDERS;
			cfg_q.take_wait_ms      <= RST_TAKE_WAIT;
			cfg_q.open_delay_ms     <= RST_OPEN_DELAY;
			cfg_q.dispense_delay_ms <= RST_DISPENSE_DELAY;
			cfg_q.close_delay_ms    <= RST_CLOSE_DELAY;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_REMIND_INTERVAL: cfg_q.remind_period_ms  <= cfg_data;
				CFG_MAX_REMINDERS:   cfg_q.max_reminders     <= cfg_data[7:0];
				CFG_TAKE_WAIT:       cfg_q.take_wait_ms      <= cfg_data;
				CFG_OPEN_DELAY:      cfg_q.open_delay_ms     <= cfg_data[15:0];
				CFG_DISPENSE_DELAY:  cfg_q.dispense_delay_ms <= cfg_data[15:0];
				CFG_CLOSE_DELAY:     cfg_q.close_delay_ms    <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_IDLE, default: '0};
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
		end else begin
			if (poll.ready) begin
				vld_s1 <= poll.valid;
			end
			if (advance) begin
				state_q <= state_nxt;
				vld_s2  <= 1'b1;
			end else if (result.ready) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (poll.ready && poll.valid) begin
			poll_s1 <= poll.item;
		end
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

endmodule

### rtl/dds_checker.sv
module dds_checker (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  res_valid,
	input  logic                  res_ready,
	input  dds_pkg::result_item_t res_item
);
	import dds_pkg::*;

	logic [2:0] ph;
	assign ph = res_item.current_phase;

	// stalled result item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_item))
		else $error("result item changed under stall");

	a_trigger_phase: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.trigger_accepted |->
			ph == PH_REMIND && res_item.dispenser_command == ACT_NONE)
		else $error("accepted trigger not in reminder");

	a_cmd_phase: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.dispenser_command != ACT_NONE |->
			(res_item.dispenser_command == ACT_OPEN && (ph == PH_OPEN || ph == PH_DISP)) ||
			(res_item.dispenser_command == ACT_DISPENSE &&
				(ph == PH_DISP || ph == PH_TAKE)) ||
			(res_item.dispenser_command == ACT_CLOSE && (ph == PH_CLOSE || ph == PH_DONE)))
		else $error("command outside its phase");

	a_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.log_outcome != LOG_NONE |->
			ph == PH_IDLE && res_item.dose_handled &&
			((res_item.log_outcome == LOG_MISSED) ==
				(res_item.notify_kind == NOTIFY_MISSED)))
		else $error("outcome without return to idle");

endmodule

bind dose_dispense_sequencer dds_checker u_dds_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_item  (result.item)
);

### dv/dose_dispense_sequencer_tb.sv
`timescale 1ns / 1ps

module dose_dispense_sequencer_tb;
	import dds_pkg::*;

	localparam int MISMATCH_PRINT_MAX = 40;
	localparam int DRAIN_CYCLES = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = CFG_CLOSE_DELAY + 3'd1;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_TRICKLE
	} rx_mode_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	dds_in_if  poll_ch ();
	dds_out_if result_ch ();

	dose_dispense_sequencer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.poll      (poll_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predicted sequencer state and settings
	cfg_t        seq_cfg;
	phase_t      seq_phase;
	logic [31:0] seq_phase_start;
	logic [31:0] seq_last_remind;
	logic [7:0]  seq_reminders;
	logic [7:0]  seq_module;
	logic        seq_cmd_issued;

	result_item_t due_results[$];

	int unsigned mismatches;
	int unsigned results_seen;
	int unsigned items_sent;
	int unsigned doses_dispensed;
	int unsigned doses_missed;
	int unsigned triggers_taken;
	int unsigned triggers_refused;
	logic [7:0]  top_reminder;
	int unsigned burst_left;
	bit          poll_valid_on;
	rx_mode_t    ready_mode;
	int unsigned ready_mode_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic cfg_t default_cfg();
		cfg_t c;
		c.remind_period_ms  = RST_REMIND_INTERVAL;
		c.max_reminders     = RST_MAX_REMINDERS;
		c.take_wait_ms      = RST_TAKE_WAIT;
		c.open_delay_ms     = RST_OPEN_DELAY;
		c.dispense_delay_ms = RST_DISPENSE_DELAY;
		c.close_delay_ms    = RST_CLOSE_DELAY;
		return c;
	endfunction

	function automatic void enter_phase(phase_t p, logic [31:0] t);
		seq_phase = p;
		seq_phase_start = t;
		seq_cmd_issued = 1'b0;
	endfunction

	function automatic result_item_t step_sequencer(poll_item_t it);
		result_item_t r;
		logic [31:0]  elapsed;
		logic [31:0]  since_remind;
		logic [8:0]   next_count;
		r = '0;
		elapsed = it.now_ms - seq_phase_start;
		since_remind = it.now_ms - seq_last_remind;
		if (it.operation == OP_TRIGGER) begin
			if (seq_phase == PH_IDLE) begin
				seq_module = it.module_number;
				enter_phase(PH_REMIND, it.now_ms);
				r.trigger_accepted = 1'b1;
			end
		end else begin
			case (seq_phase)
				PH_IDLE: begin
					if (it.schedule_pending) begin
						seq_module = it.module_number;
						enter_phase(PH_REMIND, it.now_ms);
					end
				end
				PH_REMIND: begin
					r.buzz_start = 1'b1;
					r.notify_kind = NOTIFY_REMIND;
					seq_reminders = 8'd1;
					seq_last_remind = it.now_ms;
					enter_phase(PH_WAIT, it.now_ms);
				end
				PH_WAIT: begin
					if (it.user_present) begin
						enter_phase(PH_OPEN, it.now_ms);
					end else if (since_remind >= seq_cfg.remind_period_ms) begin
						next_count = {1'b0, seq_reminders} + 9'd1;
						seq_reminders = next_count[8] ? 8'hFF : next_count[7:0];
						if (next_count > {1'b0, seq_cfg.max_reminders}) begin
							r.log_outcome = LOG_MISSED;
							r.notify_kind = NOTIFY_MISSED;
							r.dose_handled = 1'b1;
							enter_phase(PH_IDLE, it.now_ms);
						end else begin
							r.buzz_start = 1'b1;
							seq_last_remind = it.now_ms;
						end
					end
				end
				PH_OPEN: begin
					if (!seq_cmd_issued) begin
						r.dispenser_command = ACT_OPEN;
						seq_cmd_issued = 1'b1;
					end
					if (elapsed >= {16'd0, seq_cfg.open_delay_ms}) enter_phase(PH_DISP, it.now_ms);
				end
				PH_DISP: begin
					if (!seq_cmd_issued) begin
						r.dispenser_command = ACT_DISPENSE;
						seq_cmd_issued = 1'b1;
					end
					if (elapsed >= {16'd0, seq_cfg.dispense_delay_ms}) enter_phase(PH_TAKE, it.now_ms);
				end
				PH_TAKE: begin
					if (elapsed >= seq_cfg.take_wait_ms) enter_phase(PH_CLOSE, it.now_ms);
				end
				PH_CLOSE: begin
					if (!seq_cmd_issued) begin
						r.dispenser_command = ACT_CLOSE;
						seq_cmd_issued = 1'b1;
					end
					if (elapsed >= {16'd0, seq_cfg.close_delay_ms}) enter_phase(PH_DONE, it.now_ms);
				end
				default: begin
					r.log_outcome = LOG_DISPENSED;
					r.dose_handled = 1'b1;
					enter_phase(PH_IDLE, it.now_ms);
				end
			endcase
		end
		r.current_phase = seq_phase;
		r.command_module = seq_module;
		r.reminder_number = seq_reminders;
		return r;
	endfunction

	function automatic poll_item_t make_item(logic op, logic [31:0] now, logic pending,
			logic present, logic [7:0] mod_no);
		poll_item_t it;
		it.operation = op;
		it.now_ms = now;
		it.schedule_pending = pending;
		it.user_present = present;
		it.module_number = mod_no;
		return it;
	endfunction

	// times just short of, at, or past a deadline, inside it, or anywhere
	function automatic logic [31:0] near_deadline(logic [31:0] base, logic [31:0] span);
		case ($urandom_range(0, 4))
			0: return base + span - 32'd1;
			1: return base + span;
			2: return base + span + $urandom_range(1, 1000);
			3: return (span == 32'd0) ? base : base + $urandom_range(0, span - 32'd1);
			default: return $urandom;
		endcase
	endfunction

	function automatic poll_item_t next_poll(int unsigned present_pct);
		poll_item_t it;
		it = make_item(OP_POLL, $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			8'($urandom_range(0, 255)));
		case (seq_phase)
			PH_IDLE: begin
				if ($urandom_range(0, 99) < 30) begin
					it.operation = OP_TRIGGER;
				end else begin
					it.schedule_pending = ($urandom_range(0, 99) < 75);
				end
				it.now_ms = seq_phase_start + $urandom_range(0, 5000);
			end
			PH_WAIT: begin
				it.user_present = ($urandom_range(0, 99) < present_pct);
				it.now_ms = near_deadline(seq_last_remind, seq_cfg.remind_period_ms);
			end
			PH_OPEN: it.now_ms = near_deadline(seq_phase_start, {16'd0, seq_cfg.open_delay_ms});
			PH_DISP: it.now_ms = near_deadline(seq_phase_start, {16'd0, seq_cfg.dispense_delay_ms});
			PH_TAKE: it.now_ms = near_deadline(seq_phase_start, seq_cfg.take_wait_ms);
			PH_CLOSE: it.now_ms = near_deadline(seq_phase_start, {16'd0, seq_cfg.close_delay_ms});
			default: it.now_ms = seq_phase_start + $urandom_range(0, 100);
		endcase
		// stray triggers and clock jumps
		if ($urandom_range(0, 99) < 6) it.operation = OP_TRIGGER;
		if ($urandom_range(0, 99) < 3) it.now_ms = $urandom;
		return it;
	endfunction

	function automatic logic [31:0] pick_span(logic [31:0] top);
		case ($urandom_range(0, 3))
			0: return 32'd0;
			1: return top;
			2: return $urandom_range(1, 3000);
			default: return $urandom_range(0, top);
		endcase
	endfunction

	task automatic send_item(poll_item_t it);
		result_item_t r;
		int unsigned  gap;
		if (!poll_valid_on) begin
			poll_ch.valid <= 1'b1;
			poll_valid_on = 1'b1;
		end
		poll_ch.item <= it;
		do @(posedge clk); while (!poll_ch.ready);
		r = step_sequencer(it);
		due_results.push_back(r);
		items_sent++;
		if (it.operation == OP_TRIGGER) begin
			if (r.trigger_accepted) triggers_taken++;
			else triggers_refused++;
		end
		if (r.log_outcome == LOG_DISPENSED) doses_dispensed++;
		if (r.log_outcome == LOG_MISSED) doses_missed++;
		if (r.reminder_number > top_reminder) top_reminder = r.reminder_number;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 16);
			gap = $urandom_range(1, 6);
			poll_ch.valid <= 1'b0;
			poll_valid_on = 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		if (poll_valid_on) begin
			poll_ch.valid <= 1'b0;
			poll_valid_on = 1'b0;
		end
		while (due_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	// narrow registers get junk in the upper bits
	task automatic load_config(cfg_t c);
		logic [31:0] junk;
		drain_results();
		junk = $urandom;
		write_reg(CFG_REMIND_INTERVAL, c.remind_period_ms);
		write_reg(CFG_MAX_REMINDERS, {junk[31:8], c.max_reminders});
		write_reg(CFG_TAKE_WAIT, c.take_wait_ms);
		write_reg(CFG_OPEN_DELAY, {junk[31:16], c.open_delay_ms});
		write_reg(CFG_DISPENSE_DELAY, {junk[15:0], c.dispense_delay_ms});
		write_reg(CFG_CLOSE_DELAY, {junk[23:8], c.close_delay_ms});
		write_reg(CFG_IDX_SPARE + CFG_IDX_W'($urandom_range(0, 1)), $urandom);
		cfg_we <= 1'b0;
		seq_cfg = c;
	endtask

	task automatic run_polls(int unsigned count, int unsigned present_pct);
		repeat (count) send_item(next_poll(present_pct));
	endtask

	task automatic test_full_dose();
		logic [31:0] t;
		t = 32'hFFFF_FF00;
		send_item(make_item(OP_POLL, t, 1'b0, 1'b1, 8'hFF));
		send_item(make_item(OP_TRIGGER, t, 1'b0, 1'b0, 8'hA5));
		send_item(make_item(OP_TRIGGER, t + 32'd1, 1'b1, 1'b1, 8'h5A));
		send_item(make_item(OP_POLL, t + 32'd2, 1'b0, 1'b0, 8'h00));
		send_item(make_item(OP_POLL, seq_last_remind + seq_cfg.remind_period_ms - 32'd1,
			1'b1, 1'b0, 8'hFF));
		// interval reached across the wrap of the millisecond counter
		send_item(make_item(OP_POLL, seq_last_remind + seq_cfg.remind_period_ms,
			1'b1, 1'b0, 8'h12));
		send_item(make_item(OP_POLL, seq_last_remind + 32'd7, 1'b0, 1'b1, 8'h34));
		send_item(make_item(OP_POLL, seq_phase_start, 1'b0, 1'b1, 8'h56));
		send_item(make_item(OP_POLL, seq_phase_start + seq_cfg.open_delay_ms, 1'b1, 1'b0, 8'h78));
		send_item(make_item(OP_POLL, seq_phase_start + seq_cfg.dispense_delay_ms,
			1'b0, 1'b0, 8'h9A));
		send_item(make_item(OP_POLL, seq_phase_start + seq_cfg.take_wait_ms - 32'd1,
			1'b1, 1'b1, 8'hBC));
		send_item(make_item(OP_POLL, seq_phase_start + seq_cfg.take_wait_ms, 1'b0, 1'b1, 8'hDE));
		send_item(make_item(OP_POLL, seq_phase_start + seq_cfg.close_delay_ms, 1'b1, 1'b0, 8'hF0));
		send_item(make_item(OP_POLL, seq_phase_start, 1'b1, 1'b1, 8'h0F));
	endtask

	task automatic test_missed_dose();
		cfg_t c;
		c = '0;
		load_config(c);
		send_item(make_item(OP_POLL, $urandom, 1'b1, 1'b0, 8'h81));
		send_item(make_item(OP_POLL, $urandom, 1'b0, 1'b0, 8'h42));
		send_item(make_item(OP_POLL, $urandom, 1'b1, 1'b0, 8'h24));
		// zero delays: commands and phase changes fall on the same poll
		repeat (8) send_item(make_item(OP_POLL, $urandom, 1'b1, 1'b1, 8'h7E));
	endtask

	task automatic test_default_random();
		load_config(default_cfg());
		run_polls(250, 30);
	endtask

	task automatic test_reminder_saturation();
		cfg_t c;
		c = default_cfg();
		c.remind_period_ms = 32'd0;
		c.max_reminders = 8'hFF;
		load_config(c);
		run_polls(330, 0);
	endtask

	task automatic test_extreme_limits();
		cfg_t c;
		c.remind_period_ms = 32'hFFFF_FFFF;
		c.max_reminders = 8'hFF;
		c.take_wait_ms = 32'hFFFF_FFFF;
		c.open_delay_ms = 16'hFFFF;
		c.dispense_delay_ms = 16'hFFFF;
		c.close_delay_ms = 16'hFFFF;
		load_config(c);
		run_polls(200, 35);
	endtask

	task automatic test_zero_timing();
		cfg_t c;
		c = '0;
		load_config(c);
		run_polls(200, 30);
	endtask

	task automatic test_random_settings();
		cfg_t c;
		repeat (5) begin
			c.remind_period_ms = pick_span(32'hFFFF_FFFF);
			c.max_reminders = 8'(pick_span(32'hFF));
			c.take_wait_ms = pick_span(32'hFFFF_FFFF);
			c.open_delay_ms = 16'(pick_span(32'hFFFF));
			c.dispense_delay_ms = 16'(pick_span(32'hFFFF));
			c.close_delay_ms = 16'(pick_span(32'hFFFF));
			load_config(c);
			run_polls(135, $urandom_range(10, 60));
		end
	endtask

	always @(posedge clk) begin : result_check
		result_item_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MISMATCH_PRINT_MAX) begin
					$display("%0t: result item with none outstanding, expected nothing, got %h",
						$time, result_ch.item);
				end
			end else begin
				want = due_results.pop_front();
				results_seen++;
				if (result_ch.item !== want) begin
					mismatches++;
					if (mismatches <= MISMATCH_PRINT_MAX) begin
						$display("%0t: result item expected %h, got %h",
							$time, want, result_ch.item);
					end
				end
			end
		end
		if (ready_mode_left == 0) begin
			ready_mode = rx_mode_t'($urandom_range(0, 3));
			ready_mode_left = $urandom_range(20, 300);
		end else begin
			ready_mode_left--;
		end
		case (ready_mode)
			RX_OPEN: result_ch.ready <= 1'b1;
			RX_COIN: result_ch.ready <= 1'($urandom_range(0, 1));
			RX_SPARSE: result_ch.ready <= ($urandom_range(0, 3) == 0);
			default: result_ch.ready <= ($urandom_range(0, 15) == 0);
		endcase
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_REMIND_INTERVAL;
		cfg_data <= '0;
		poll_ch.valid <= 1'b0;
		poll_ch.item <= '0;
		seq_cfg = default_cfg();
		seq_phase = PH_IDLE;
		seq_phase_start = '0;
		seq_last_remind = '0;
		seq_reminders = '0;
		seq_module = '0;
		seq_cmd_issued = 1'b0;
		top_reminder = '0;
		poll_valid_on = 1'b0;
		burst_left = 0;
		ready_mode = RX_OPEN;
		ready_mode_left = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_full_dose();
		test_missed_dose();
		test_default_random();
		test_reminder_saturation();
		test_extreme_limits();
		test_zero_timing();
		test_random_settings();
		drain_results();

		$display("covered %0d items and %0d results: %0d doses dispensed, %0d missed",
			items_sent, results_seen, doses_dispensed, doses_missed);
		$display("forced triggers %0d taken, %0d refused; reminder count up to %0d; %0d mismatches",
			triggers_taken, triggers_refused, top_reminder, mismatches);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
